[src/frc_pkg.sv]
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants for the framed relay command controller
// Control word layout, sequencer status, microcode codes and framing bytes.
// ----------------------------------------------------------------------------
package frc_pkg;

   localparam int UPC_W = 6;
   localparam int TIME_W = 32;
   localparam int BYTE_W = 8;
   localparam int RELAY_W = 8;

   typedef logic [UPC_W-1:0] upc_type;
   typedef logic [2:0] op_type;
   typedef logic [0:0] src_type;
   typedef logic [1:0] last_type;
   typedef logic [2:0] jump_type;

   // Datapath operations
   localparam op_type OP_NOP      = 3'd0;
   localparam op_type OP_TICK_INC = 3'd1;
   localparam op_type OP_TICK_SUB = 3'd2;
   localparam op_type OP_TICK_CMP = 3'd3;
   localparam op_type OP_DECODE   = 3'd4;
   localparam op_type OP_EMIT     = 3'd5;

   // Emitted byte source
   localparam src_type SRC_LIT = 1'b0;
   localparam src_type SRC_CMD = 1'b1;

   // Last-word marking
   localparam last_type LAST_NONE   = 2'd0;
   localparam last_type LAST_ALWAYS = 2'd1;
   localparam last_type LAST_NO_SF  = 2'd2;

   // Sequencing
   localparam jump_type J_NEXT      = 3'd0;
   localparam jump_type J_END       = 3'd1;
   localparam jump_type J_NO_HB     = 3'd2;
   localparam jump_type J_NO_SF_END = 3'd3;
   localparam jump_type J_BAD       = 3'd4;
   localparam jump_type J_MORE      = 3'd5;

   // Microprogram entry and branch addresses
   localparam upc_type UA_TICK    = 6'd0;
   localparam upc_type UA_HB_DONE = 6'd15;
   localparam upc_type UA_DECODE  = 6'd28;
   localparam upc_type UA_ECHO    = 6'd31;
   localparam upc_type UA_INVALID = 6'd33;

   // Configuration register indexes
   localparam logic REG_HEARTBEAT_INTERVAL = 1'b0;
   localparam logic REG_SAFETY_TIMEOUT     = 1'b1;

   localparam logic [TIME_W-1:0] HEARTBEAT_RESET = 32'd60000;
   localparam logic [TIME_W-1:0] SAFETY_RESET    = 32'd7200000;

   localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
   localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;

   typedef struct packed {
      op_type              op;
      src_type             src;
      logic [BYTE_W-1:0]   lit;
      last_type            last;
      jump_type            jump;
      upc_type             target;
   } ctrl_type;

   typedef struct packed {
      logic in_frame;
      logic hb_fire;
      logic sf_fire;
      logic cmd_bad;
      logic cmd_more;
      logic out_free;
   } status_type;

endpackage

[src/frc_ucode_rom.sv]
// ----------------------------------------------------------------------------
// frc_ucode_rom: microprogram store
// One control word per step: tick evaluation, heartbeat and safety-off
// messages, command decode, echo loop and the INVALID reply.
// ----------------------------------------------------------------------------
module frc_ucode_rom (
   input  frc_pkg::upc_type  upc,
   output frc_pkg::ctrl_type ctrl
);

   function automatic frc_pkg::ctrl_type step_word(input frc_pkg::op_type op,
                                                   input frc_pkg::jump_type jmp,
                                                   input frc_pkg::upc_type tgt);
      frc_pkg::ctrl_type w;
      w.op = op;
      w.src = frc_pkg::SRC_LIT;
      w.lit = 8'h00;
      w.last = frc_pkg::LAST_NONE;
      w.jump = jmp;
      w.target = tgt;
      return w;
   endfunction

   function automatic frc_pkg::ctrl_type chr(input logic [7:0] ch);
      frc_pkg::ctrl_type w;
      w = step_word(frc_pkg::OP_EMIT, frc_pkg::J_NEXT, '0);
      w.lit = ch;
      return w;
   endfunction

   function automatic frc_pkg::ctrl_type tail(input frc_pkg::last_type lst,
                                              input frc_pkg::jump_type jmp);
      frc_pkg::ctrl_type w;
      w = chr(frc_pkg::CH_ETX);
      w.last = lst;
      w.jump = jmp;
      return w;
   endfunction

   always_comb begin
      unique case (upc)
         // tick: advance time, evaluate both timers, branch
         6'd0:  ctrl = step_word(frc_pkg::OP_TICK_INC, frc_pkg::J_NEXT, '0);
         6'd1:  ctrl = step_word(frc_pkg::OP_TICK_SUB, frc_pkg::J_NEXT, '0);
         6'd2:  ctrl = step_word(frc_pkg::OP_TICK_CMP, frc_pkg::J_NEXT, '0);
         6'd3:  ctrl = step_word(frc_pkg::OP_NOP, frc_pkg::J_NO_HB, frc_pkg::UA_HB_DONE);
         6'd4:  ctrl = chr(frc_pkg::CH_STX);
         6'd5:  ctrl = chr("H");
         6'd6:  ctrl = chr("E");
         6'd7:  ctrl = chr("A");
         6'd8:  ctrl = chr("R");
         6'd9:  ctrl = chr("T");
         6'd10: ctrl = chr("B");
         6'd11: ctrl = chr("E");
         6'd12: ctrl = chr("A");
         6'd13: ctrl = chr("T");
         6'd14: ctrl = tail(frc_pkg::LAST_NO_SF, frc_pkg::J_NEXT);
         6'd15: ctrl = step_word(frc_pkg::OP_NOP, frc_pkg::J_NO_SF_END, '0);
         6'd16: ctrl = chr(frc_pkg::CH_STX);
         6'd17: ctrl = chr("S");
         6'd18: ctrl = chr("A");
         6'd19: ctrl = chr("F");
         6'd20: ctrl = chr("E");
         6'd21: ctrl = chr("T");
         6'd22: ctrl = chr("Y");
         6'd23: ctrl = chr("-");
         6'd24: ctrl = chr("O");
         6'd25: ctrl = chr("F");
         6'd26: ctrl = chr("F");
         6'd27: ctrl = tail(frc_pkg::LAST_ALWAYS, frc_pkg::J_END);
         // end of frame: decode, then echo or reject
         6'd28: ctrl = step_word(frc_pkg::OP_DECODE, frc_pkg::J_NEXT, '0);
         6'd29: ctrl = step_word(frc_pkg::OP_NOP, frc_pkg::J_BAD, frc_pkg::UA_INVALID);
         6'd30: ctrl = chr(frc_pkg::CH_STX);
         6'd31: begin
            ctrl = step_word(frc_pkg::OP_EMIT, frc_pkg::J_MORE, frc_pkg::UA_ECHO);
            ctrl.src = frc_pkg::SRC_CMD;
         end
         6'd32: ctrl = tail(frc_pkg::LAST_ALWAYS, frc_pkg::J_END);
         6'd33: ctrl = chr(frc_pkg::CH_STX);
         6'd34: ctrl = chr("I");
         6'd35: ctrl = chr("N");
         6'd36: ctrl = chr("V");
         6'd37: ctrl = chr("A");
         6'd38: ctrl = chr("L");
         6'd39: ctrl = chr("I");
         6'd40: ctrl = chr("D");
         6'd41: ctrl = tail(frc_pkg::LAST_ALWAYS, frc_pkg::J_END);
         default: ctrl = step_word(frc_pkg::OP_NOP, frc_pkg::J_END, '0);
      endcase
   end

endmodule

[src/frc_sequencer.sv]
// ----------------------------------------------------------------------------
// frc_sequencer: step counter and branch unit
// Dispatches ticks and end-of-frame bytes into the microprogram and walks it.
// ----------------------------------------------------------------------------
module frc_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  logic                 req_is_tick,
   input  logic                 req_is_etx,
   input  frc_pkg::status_type  status,
   output logic                 busy,
   output logic                 step_fire,
   output frc_pkg::ctrl_type    ctrl
);

   logic              busy_ff, busy_in;
   frc_pkg::upc_type  upc_ff, upc_in;
   frc_pkg::upc_type  upc_next;

   frc_ucode_rom u_rom (
      .upc  (upc_ff),
      .ctrl (ctrl)
   );

   assign busy      = busy_ff;
   assign step_fire = busy_ff && ((ctrl.op != frc_pkg::OP_EMIT) || status.out_free);
   assign upc_next  = upc_ff + 1'b1;

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (!busy_ff) begin
         if (req_accept && req_is_tick) begin
            busy_in = 1'b1;
            upc_in  = frc_pkg::UA_TICK;
         end else if (req_accept && status.in_frame && req_is_etx) begin
            busy_in = 1'b1;
            upc_in  = frc_pkg::UA_DECODE;
         end
      end else if (step_fire) begin
         unique case (ctrl.jump)
            frc_pkg::J_NEXT: upc_in = upc_next;
            frc_pkg::J_END:  busy_in = 1'b0;
            frc_pkg::J_NO_HB: upc_in = status.hb_fire ? upc_next : ctrl.target;
            frc_pkg::J_NO_SF_END: begin
               if (status.sf_fire) begin
                  upc_in = upc_next;
               end else begin
                  busy_in = 1'b0;
               end
            end
            frc_pkg::J_BAD:  upc_in = status.cmd_bad ? ctrl.target : upc_next;
            frc_pkg::J_MORE: upc_in = status.cmd_more ? ctrl.target : upc_next;
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

endmodule

[src/frc_datapath.sv]
// ----------------------------------------------------------------------------
// frc_datapath: command buffer, relay and timer state, reply output register
// Carries out the operation named by the current control word.
// ----------------------------------------------------------------------------
module frc_datapath #(
   parameter int MAX_CMD_LEN = 8,
   parameter int RELAY_COUNT = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic                           csr_index,
   input  logic [frc_pkg::TIME_W-1:0]     csr_data,
   input  logic                           req_accept,
   input  logic                           req_is_tick,
   input  logic [frc_pkg::BYTE_W-1:0]     req_byte,
   input  logic                           step_fire,
   input  frc_pkg::ctrl_type              ctrl,
   output frc_pkg::status_type            status,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int LEN_W = $clog2(MAX_CMD_LEN + 1);
   localparam int IDX_W = $clog2(MAX_CMD_LEN);
   localparam logic [8:0] ALL_MASK_WIDE = 9'((1 << RELAY_COUNT) - 1);
   localparam logic [7:0] ALL_MASK = ALL_MASK_WIDE[7:0];
   localparam logic [7:0] SEL_MAX = 8'(48 + RELAY_COUNT);

   typedef logic [frc_pkg::TIME_W-1:0] time_type;

   time_type hb_interval_ff, hb_interval_in;
   time_type sf_timeout_ff, sf_timeout_in;
   logic     in_frame_ff, in_frame_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic     ovf_ff, ovf_in;
   logic [7:0] relay_ff, relay_in;
   time_type now_ff, now_in;
   time_type hb_stamp_ff, hb_stamp_in;
   time_type on_stamp_ff, on_stamp_in;
   time_type hb_diff_ff, hb_diff_in;
   time_type sf_diff_ff, sf_diff_in;
   logic     hb_gt_ff, hb_gt_in;
   logic     sf_gt_ff, sf_gt_in;
   logic     hb_fire_ff, hb_fire_in;
   logic     sf_fire_ff, sf_fire_in;
   logic     known_ff, known_in;
   logic [LEN_W-1:0] ci_ff, ci_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [7:0] rsp_relay_ff, rsp_relay_in;
   logic     rsp_last_ff, rsp_last_in;

   logic [7:0] chars_ff [MAX_CMD_LEN];
   logic       chars_we;
   logic [7:0] chars_wdata;

   logic       out_free;
   logic       is_on, is_off, sel_all, sel_num, known;
   logic [7:0] sel, num_idx, num_mask, mask;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Command decode from the fixed buffer positions
   assign sel      = chars_ff[1];
   assign num_idx  = sel - "1";
   assign num_mask = (num_idx < 8'd8) ? (8'h01 << num_idx[2:0]) : 8'h00;
   assign sel_all  = (sel == "A");
   assign sel_num  = (sel >= "1") && (sel <= SEL_MAX);
   assign mask     = sel_all ? ALL_MASK : num_mask;
   assign is_on    = (len_ff == LEN_W'(5)) && (chars_ff[2] == "-") &&
                     (chars_ff[3] == "O") && (chars_ff[4] == "N");
   assign is_off   = (len_ff == LEN_W'(6)) && (chars_ff[2] == "-") &&
                     (chars_ff[3] == "O") && (chars_ff[4] == "F") && (chars_ff[5] == "F");
   assign known    = !ovf_ff && (chars_ff[0] == "R") && (is_on || is_off) &&
                     (sel_all || sel_num);

   always_comb begin
      hb_interval_in = hb_interval_ff;
      sf_timeout_in  = sf_timeout_ff;
      in_frame_in    = in_frame_ff;
      len_in         = len_ff;
      ovf_in         = ovf_ff;
      relay_in       = relay_ff;
      now_in         = now_ff;
      hb_stamp_in    = hb_stamp_ff;
      on_stamp_in    = on_stamp_ff;
      hb_diff_in     = hb_diff_ff;
      sf_diff_in     = sf_diff_ff;
      hb_gt_in       = hb_gt_ff;
      sf_gt_in       = sf_gt_ff;
      hb_fire_in     = hb_fire_ff;
      sf_fire_in     = sf_fire_ff;
      known_in       = known_ff;
      ci_in          = ci_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_relay_in   = rsp_relay_ff;
      rsp_last_in    = rsp_last_ff;
      chars_we       = 1'b0;
      chars_wdata    = req_byte;

      if (csr_write) begin
         unique case (csr_index)
            frc_pkg::REG_HEARTBEAT_INTERVAL: hb_interval_in = csr_data;
            frc_pkg::REG_SAFETY_TIMEOUT:     sf_timeout_in  = csr_data;
            default: ;
         endcase
      end

      // Plain bytes finish in the accept cycle; end of frame goes to the sequencer
      if (req_accept && !req_is_tick) begin
         if (!in_frame_ff) begin
            if (req_byte == frc_pkg::CH_STX) begin
               in_frame_in = 1'b1;
               len_in      = '0;
               ovf_in      = 1'b0;
            end
         end else if (req_byte != frc_pkg::CH_ETX) begin
            if (len_ff < LEN_W'(MAX_CMD_LEN)) begin
               chars_we = 1'b1;
               len_in   = len_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
      end

      if (step_fire) begin
         case (ctrl.op)
            frc_pkg::OP_TICK_INC: now_in = now_ff + 1'b1;
            frc_pkg::OP_TICK_SUB: begin
               hb_diff_in = now_ff - hb_interval_ff;
               sf_diff_in = now_ff - sf_timeout_ff;
               hb_gt_in   = now_ff > hb_interval_ff;
               sf_gt_in   = now_ff > sf_timeout_ff;
            end
            frc_pkg::OP_TICK_CMP: begin
               hb_fire_in = hb_gt_ff && (hb_stamp_ff < hb_diff_ff);
               sf_fire_in = (relay_ff != 8'h00) && sf_gt_ff && (on_stamp_ff < sf_diff_ff);
               if (hb_fire_in) begin
                  hb_stamp_in = now_ff;
               end
               if (sf_fire_in) begin
                  relay_in = 8'h00;
               end
            end
            frc_pkg::OP_DECODE: begin
               known_in    = known;
               in_frame_in = 1'b0;
               ci_in       = '0;
               if (known && is_on) begin
                  relay_in    = relay_ff | mask;
                  on_stamp_in = now_ff;
               end else if (known) begin
                  relay_in = relay_ff & ~mask;
               end
            end
            frc_pkg::OP_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_relay_in = relay_ff;
               rsp_last_in  = (ctrl.last == frc_pkg::LAST_ALWAYS) ||
                              ((ctrl.last == frc_pkg::LAST_NO_SF) && !sf_fire_ff);
               if (ctrl.src == frc_pkg::SRC_CMD) begin
                  rsp_byte_in = chars_ff[ci_ff[IDX_W-1:0]];
                  ci_in       = ci_ff + 1'b1;
               end else begin
                  rsp_byte_in = ctrl.lit;
               end
            end
            default: ;
         endcase
      end
   end

   assign status.in_frame = in_frame_ff;
   assign status.hb_fire  = hb_fire_ff;
   assign status.sf_fire  = sf_fire_ff;
   assign status.cmd_bad  = !known_ff;
   assign status.cmd_more = LEN_W'(ci_ff + 1'b1) < len_ff;
   assign status.out_free = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_relay_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (chars_we) begin
         chars_ff[len_ff[IDX_W-1:0]] <= chars_wdata;
      end
   end

   always_ff @(posedge clock) begin
      hb_diff_ff   <= hb_diff_in;
      sf_diff_ff   <= sf_diff_in;
      hb_gt_ff     <= hb_gt_in;
      sf_gt_ff     <= sf_gt_in;
      hb_fire_ff   <= hb_fire_in;
      sf_fire_ff   <= sf_fire_in;
      known_ff     <= known_in;
      ci_ff        <= ci_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_relay_ff <= rsp_relay_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_interval_ff <= frc_pkg::HEARTBEAT_RESET;
         sf_timeout_ff  <= frc_pkg::SAFETY_RESET;
         in_frame_ff    <= 1'b0;
         len_ff         <= '0;
         ovf_ff         <= 1'b0;
         relay_ff       <= 8'h00;
         now_ff         <= '0;
         hb_stamp_ff    <= '0;
         on_stamp_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         hb_interval_ff <= hb_interval_in;
         sf_timeout_ff  <= sf_timeout_in;
         in_frame_ff    <= in_frame_in;
         len_ff         <= len_in;
         ovf_ff         <= ovf_in;
         relay_ff       <= relay_in;
         now_ff         <= now_in;
         hb_stamp_ff    <= hb_stamp_in;
         on_stamp_ff    <= on_stamp_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

endmodule

[src/framed_relay_command_controller_core.sv]
// A plain received byte is handled in its accept cycle; a tick runs its time increment,
// subtract, compare and heartbeat branch steps before its first reply word, an end-of-frame
// byte its decode and reject branch steps; then one word per cycle while the single output
// register is free. The input waits while a program runs, also while it stalls on that
// register; the microcode sequencer steps once per cycle unless an emit step is stalled.
// Reset (synchronous, active high): frame idle, relays off, time and stamps zero.
// ----------------------------------------------------------------------------
// framed_relay_command_controller_core: framed relay command controller
// Collects STX/ETX framed text commands, switches relays, echoes commands and
// sends heartbeat and safety-off messages on millisecond ticks.
// ----------------------------------------------------------------------------
module framed_relay_command_controller_core #(
   parameter int MAX_CMD_LEN = 8,
   parameter int RELAY_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic        req_tuser,    // [0] cmd: 0 byte, 1 tick
   // reply words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] tx_byte, [15:8] relay_state
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic                 busy;
   logic                 step_fire;
   logic                 req_accept;
   frc_pkg::ctrl_type    ctrl;
   frc_pkg::status_type  status;

   // Take a new word only while no microprogram is running
   assign req_tready = !busy;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   frc_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_is_tick (req_tuser),
      .req_is_etx  (req_tdata == frc_pkg::CH_ETX),
      .status      (status),
      .busy        (busy),
      .step_fire   (step_fire),
      .ctrl        (ctrl)
   );

   frc_datapath #(
      .MAX_CMD_LEN (MAX_CMD_LEN),
      .RELAY_COUNT (RELAY_COUNT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_accept  (req_accept),
      .req_is_tick (req_tuser),
      .req_byte    (req_tdata),
      .step_fire   (step_fire),
      .ctrl        (ctrl),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
